// ===== rtl/fpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Framed packet receiver package
// Shared types, field widths, register indexes and default sizes.
// ----------------------------------------------------------------------------
package fpr_pkg;

	// Default buffer depth in bytes; the top level takes it as a parameter.
	localparam int BUF_DEPTH_DEF = 64;

	// Bytes in one frame: header, body and tail.
	localparam int FRAME_BYTES = 8;

	// Field widths.
	localparam int OP_W      = 2;
	localparam int BYTE_W    = 8;
	localparam int RD_IDX_W  = 6;
	localparam int COUNT_W   = 7;
	localparam int ERR_W     = 5;
	localparam int OVF_W     = 2;
	localparam int BODY_W    = 3;
	localparam int CFG_IDX_W = 2;

	// Stream widths, packed to whole bytes.
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_USED_W  = COUNT_W + 3 + ERR_W + OVF_W + BYTE_W;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

	// Body byte count at which the next byte must be the tail.
	localparam logic [BODY_W-1:0] BODY_LAST = BODY_W'(FRAME_BYTES - 2);

	// Reset value of the error limit register.
	localparam logic [ERR_W-1:0] ERR_LIMIT_RST = ERR_W'(20);

	typedef enum logic [OP_W-1:0] {
		OP_BYTE  = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEADER = 2'd0,
		CFG_TAIL   = 2'd1,
		CFG_LIMIT  = 2'd2,
		CFG_SPARE  = 2'd3
	} cfg_idx_t;

endpackage

// ===== rtl/fpr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module fpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// The read data holds while re is low.
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/framed_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// Framed packet receiver
// Stores received bytes, finds header/tail framed packets and reports status.
// ----------------------------------------------------------------------------
// Path: an accepted request is held in the input stage; its result is then
// registered in the result register. Throughput: one request per cycle while
// m_tready is high, as the single input stage and the result register allow.
// Reset: arst_n clears all status and returns the registers to their defaults
// at once; the buffer needs no clearing pass, as a high-water mark makes
// unwritten entries read as zero.
// ----------------------------------------------------------------------------
module framed_packet_receiver
	import fpr_pkg::*;
#(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration write port.
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [BYTE_W-1:0]      cfg_data,
	// Request stream. tdata, lowest bit up: op[1:0], rx_byte[9:2],
	// read_index[15:10].
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// Result stream. tdata, lowest bit up: byte_count[6:0], packet_ready[7],
	// has_received[8], frame_error[9], error_total[14:10],
	// overflow_total[16:15], read_data[24:17], zero padding[31:25].
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	// AW indexes the buffer; CW holds a count up to the full depth. The buffer
	// is split into an even and an odd bank so that a byte and the zero
	// terminator after it can be written in the same cycle.
	localparam int AW         = $clog2(BUF_DEPTH);
	localparam int CW         = $clog2(BUF_DEPTH + 1);
	localparam int WW         = (CW > RD_IDX_W) ? CW : RD_IDX_W;
	localparam int BANK_DEPTH = 2 ** (AW - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);
	localparam logic [CW-1:0] LAST_C  = CW'(BUF_DEPTH - 1);

	// Configuration registers.
	logic [BYTE_W-1:0] header_q;
	logic [BYTE_W-1:0] tail_q;
	logic [ERR_W-1:0]  limit_q;

	// Receiver state. hw_q is the high-water mark: entries at or above it have
	// been zeroed by an overflow and not written since. zero0_q marks entry 0
	// as zeroed by a full reset of the receiver.
	logic [AW-1:0]     fill_q;
	logic [CW-1:0]     hw_q;
	logic              zero0_q;
	logic              ready_q;
	logic              got_q;
	logic              hdr_seen_q;
	logic [BODY_W-1:0] body_q;
	logic [ERR_W-1:0]  fail_q;
	logic [OVF_W-1:0]  ovf_q;

	// Input stage.
	logic              valid_s1;
	op_t               op_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [RD_IDX_W-1:0] idx_s1;

	// Result stage.
	logic               valid_s2;
	logic [COUNT_W-1:0] count_s2;
	logic               ready_s2;
	logic               got_s2;
	logic               err_s2;
	logic [ERR_W-1:0]   total_s2;
	logic [OVF_W-1:0]   ovf_s2;
	logic               rhit_s2;
	logic               rodd_s2;

	logic adv;

	// The input stage moves on whenever the result register is free or being
	// emptied this cycle, so a request may be taken in every cycle while m_tready is high.
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = valid_s2;

	// ------------------------------------------------------------------
	// Next-state logic for the request held in the input stage.
	// ------------------------------------------------------------------
	logic [CW-1:0]     fill_ext;
	logic [CW-1:0]     fill_p1;
	logic [CW-1:0]     fill_n;
	logic [CW-1:0]     hw_n;
	logic              zero0_n;
	logic              ready_n;
	logic              got_n;
	logic              hdr_seen_n;
	logic [BODY_W-1:0] body_n;
	logic [ERR_W-1:0]  fail_n;
	logic [OVF_W-1:0]  ovf_n;
	logic              err_n;

	assign fill_ext = CW'(fill_q);
	assign fill_p1  = fill_ext + CW'(1);

	always_comb begin
		fill_n     = fill_ext;
		hw_n       = hw_q;
		zero0_n    = zero0_q;
		ready_n    = ready_q;
		got_n      = got_q;
		hdr_seen_n = hdr_seen_q;
		body_n     = body_q;
		fail_n     = fail_q;
		ovf_n      = ovf_q;
		err_n      = 1'b0;

		case (op_s1)
			OP_BYTE: begin
				// The byte lands at the fill position; the mark only grows when
				// the write is at its edge.
				fill_n = fill_p1;
				got_n  = 1'b1;
				if (fill_ext == hw_q) begin
					hw_n = fill_p1;
				end
				if (fill_q == '0) begin
					zero0_n = 1'b0;
				end

				// Framing is paused while a packet waits to be consumed.
				if (!ready_q) begin
					if (hdr_seen_q) begin
						if (body_q == BODY_LAST) begin
							if (byte_s1 == tail_q) begin
								ready_n = 1'b1;
							end else begin
								err_n   = 1'b1;
								fail_n  = fail_q + ERR_W'(1);
								fill_n  = '0;
								ready_n = 1'b0;
								got_n   = 1'b0;
							end
							hdr_seen_n = 1'b0;
							body_n     = '0;
						end else begin
							body_n = body_q + BODY_W'(1);
						end
					end else if (byte_s1 == header_q) begin
						hdr_seen_n = 1'b1;
					end
				end

				// Too many failed packets: the whole receiver starts over, and of
				// the buffer only entry 0 is cleared.
				if (fail_n >= limit_q) begin
					fail_n     = '0;
					hdr_seen_n = 1'b0;
					body_n     = '0;
					fill_n     = '0;
					ready_n    = 1'b0;
					got_n      = 1'b0;
					ovf_n      = '0;
					zero0_n    = 1'b1;
				end

				// Running past the end of the buffer empties it in one go by
				// dropping the high-water mark to zero.
				if (fill_n > LAST_C) begin
					fill_n = '0;
					ovf_n  = ovf_q + OVF_W'(1);
					hw_n   = '0;
				end
			end
			OP_CLEAR: begin
				fill_n  = '0;
				ready_n = 1'b0;
				got_n   = 1'b0;
			end
			default: begin
				// Reads and the idle code leave the state alone.
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Buffer banks.
	// ------------------------------------------------------------------
	logic              byte_we;
	logic              term_ok;
	logic [AW-2:0]     fill_a;
	logic [AW-2:0]     term_a;
	logic [WW-1:0]     rd_w;
	logic              rd_hit;
	logic              rd_re;
	logic              even_we;
	logic              odd_we;
	logic [AW-2:0]     even_wa;
	logic [AW-2:0]     odd_wa;
	logic [BYTE_W-1:0] even_wd;
	logic [BYTE_W-1:0] odd_wd;
	logic [BYTE_W-1:0] even_rd;
	logic [BYTE_W-1:0] odd_rd;

	assign byte_we = adv && (op_s1 == OP_BYTE);
	// The zero terminator goes one place past the byte when that is inside.
	assign term_ok = fill_p1 < DEPTH_C;
	assign fill_a  = fill_q[AW-1:1];
	assign term_a  = fill_p1[AW-1:1];

	// The byte and its terminator always fall in different banks.
	assign even_we = byte_we && (!fill_q[0] || term_ok);
	assign odd_we  = byte_we && (fill_q[0] || term_ok);
	assign even_wa = fill_q[0] ? term_a : fill_a;
	assign odd_wa  = fill_q[0] ? fill_a : term_a;
	assign even_wd = fill_q[0] ? '0 : byte_s1;
	assign odd_wd  = fill_q[0] ? byte_s1 : '0;

	// A read returns stored data only below the high-water mark and, for
	// entry 0, only if no full reset has cleared it since.
	assign rd_w   = WW'(idx_s1);
	assign rd_hit = (rd_w < WW'(hw_q)) && !((rd_w == '0) && zero0_q);
	assign rd_re  = adv && (op_s1 == OP_READ);

	fpr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BANK_DEPTH)
	) u_even_bank (
		.clk   (clk),
		.we    (even_we),
		.waddr (even_wa),
		.wdata (even_wd),
		.re    (rd_re),
		.raddr (rd_w[AW-1:1]),
		.rdata (even_rd)
	);

	fpr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BANK_DEPTH)
	) u_odd_bank (
		.clk   (clk),
		.we    (odd_we),
		.waddr (odd_wa),
		.wdata (odd_wd),
		.re    (rd_re),
		.raddr (rd_w[AW-1:1]),
		.rdata (odd_rd)
	);

	// ------------------------------------------------------------------
	// Registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= '0;
			tail_q   <= '0;
			limit_q  <= ERR_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_HEADER: header_q <= cfg_data;
				CFG_TAIL:   tail_q   <= cfg_data;
				CFG_LIMIT:  limit_q  <= cfg_data[ERR_W-1:0];
				default: begin
					// Writes to the spare index are dropped.
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			hw_q       <= '0;
			zero0_q    <= 1'b0;
			ready_q    <= 1'b0;
			got_q      <= 1'b0;
			hdr_seen_q <= 1'b0;
			body_q     <= '0;
			fail_q     <= '0;
			ovf_q      <= '0;
		end else if (adv) begin
			fill_q     <= fill_n[AW-1:0];
			hw_q       <= hw_n;
			zero0_q    <= zero0_n;
			ready_q    <= ready_n;
			got_q      <= got_n;
			hdr_seen_q <= hdr_seen_n;
			body_q     <= body_n;
			fail_q     <= fail_n;
			ovf_q      <= ovf_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= op_t'(s_tdata[OP_W-1:0]);
			byte_s1 <= s_tdata[OP_W +: BYTE_W];
			idx_s1  <= s_tdata[OP_W + BYTE_W +: RD_IDX_W];
		end
		if (adv) begin
			count_s2 <= COUNT_W'(fill_n);
			ready_s2 <= ready_n;
			got_s2   <= got_n;
			err_s2   <= err_n;
			total_s2 <= fail_n;
			ovf_s2   <= ovf_n;
			rhit_s2  <= rd_hit && (op_s1 == OP_READ);
			rodd_s2  <= rd_w[0];
		end
	end

	// ------------------------------------------------------------------
	// Result packing. The bank outputs hold while the result waits.
	// ------------------------------------------------------------------
	logic [BYTE_W-1:0] read_data;

	assign read_data = rhit_s2 ? (rodd_s2 ? odd_rd : even_rd) : '0;

	assign m_tdata = {{OUT_PAD_W{1'b0}}, read_data, ovf_s2, total_s2, err_s2,
		got_s2, ready_s2, count_s2};

endmodule
